[sv/ces_pkg.sv]
// Shared types and codes for the control endpoint sequencer.
package ces_pkg;

  typedef enum logic [2:0] {
    OP_SETUP     = 3'd0,
    OP_START_IN  = 3'd1,
    OP_START_OUT = 3'd2,
    OP_IN_SENT   = 3'd3,
    OP_OUT_RCVD  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_DATA_IN    = 3'd1,
    PH_LAST_IN    = 3'd2,
    PH_STATUS_OUT = 3'd3,
    PH_DATA_OUT   = 3'd4,
    PH_LAST_OUT   = 3'd5,
    PH_STATUS_IN  = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_SETUP_OK  = 4'd1,
    ACT_SEND      = 4'd2,
    ACT_STALL     = 4'd3,
    ACT_ARM_OUT   = 4'd4,
    ACT_TAKE      = 4'd5,
    ACT_TAKE_LAST = 4'd6,
    ACT_RX_DONE   = 4'd7,
    ACT_TX_DONE   = 4'd8
  } action_t;

  // Bytes in a setup packet
  localparam logic [6:0] SETUP_BYTES = 7'd8;

  typedef struct packed {
    action_t     action;
    logic [6:0]  byte_count;
    logic [11:0] buffer_offset;
    logic [11:0] max_buffer_length;
    phase_t      phase_after;
  } result_t;

endpackage

[sv/control_endpoint_sequencer.sv]
// Endpoint-0 control transfer sequencer with a two-entry result buffer.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid in_ready in_op in_length in_rx_bytes      | in
//  out     | out_valid out_ready out_action out_byte_count      | out
//          | out_buffer_offset out_max_buffer_length            |
//          | out_phase_after                                    |
//
// One word is accepted per cycle while in_ready is high; its result is
// registered in the output register, or in the skid if out is stalled. The
// phase and transfer state update in the same cycle the word is accepted, so
// back-to-back words see each other's effect directly. A skid register behind
// the output register absorbs one extra result, so in_ready is a flop (low
// only while the skid holds a word). Synchronous active-low reset returns the
// phase to idle, clears the transfer state and empties both result slots.
module control_endpoint_sequencer #(
  parameter int MAX_PACKET   = 64,
  parameter int MAX_TRANSFER = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_length,
  input  logic [6:0]  in_rx_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_action,
  output logic [6:0]  out_byte_count,
  output logic [11:0] out_buffer_offset,
  output logic [11:0] out_max_buffer_length,
  output logic [2:0]  out_phase_after
);
  import ces_pkg::*;

  localparam logic [15:0] MP16    = 16'(MAX_PACKET);
  localparam logic [15:0] MP2_16  = 16'(2 * MAX_PACKET);
  localparam logic [6:0]  MP7     = 7'(MAX_PACKET);
  localparam logic [11:0] MP12    = 12'(MAX_PACKET);
  localparam logic [15:0] MT16    = 16'(MAX_TRANSFER);
  localparam logic [16:0] MT17    = 17'(MAX_TRANSFER);

  // Transfer state
  phase_t      phase_r, phase_nxt;
  logic [15:0] pend_r, pend_nxt;     // bytes left to send, or bytes taken so far
  logic [15:0] req_r, req_nxt;       // wLength of the last good setup
  logic [11:0] soff_r, soff_nxt;     // buffer offset of the next IN packet
  logic        short_r, short_nxt;   // reply shorter than request: may need a ZLP

  // Result buffer
  result_t out_r, out_nxt, skid_r, skid_nxt, res;
  logic    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic push, pop;
  op_t  op;

  assign op       = op_t'(in_op);
  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // Start of IN stage: clip the reply to the request and the buffer
  logic [15:0] r_req, r_clip;
  assign r_req  = (in_length > req_r) ? req_r : in_length;
  assign r_clip = (r_req > MT16) ? MT16 : r_req;

  // Send one IN packet, either fresh from a start or continuing a stage
  logic [15:0] snd_pend;
  logic [11:0] snd_soff;
  logic        snd_short, snd_more;
  assign snd_pend  = (op == OP_START_IN) ? r_clip : pend_r;
  assign snd_soff  = (op == OP_START_IN) ? 12'd0 : soff_r;
  assign snd_short = (op == OP_START_IN) ? (r_clip < req_r) : short_r;
  assign snd_more  = snd_pend > MP16;

  // Final packet of a multiple-of-packet-size short reply needs a trailing ZLP
  phase_t snd_phase;
  assign snd_phase = (snd_more || (snd_short && snd_pend == MP16)) ? PH_DATA_IN
                                                                   : PH_LAST_IN;

  // Take one OUT packet
  logic [15:0] rem;
  logic [6:0]  pkt;
  logic [16:0] take_sum;
  logic        take_ok, take_last;
  assign rem       = (req_r > pend_r) ? (req_r - pend_r) : 16'd0;
  assign pkt       = (rem < MP16) ? rem[6:0] : MP7;
  assign take_sum  = {1'b0, pend_r} + 17'(pkt);
  assign take_ok   = !(in_rx_bytes < pkt) && !(take_sum > MT17);
  // After this packet at most one more packet remains
  assign take_last = rem <= MP2_16;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    req_nxt   = req_r;
    soff_nxt  = soff_r;
    short_nxt = short_r;
    if (push) begin
      case (op)
        OP_SETUP: begin
          phase_nxt = PH_IDLE;
          if (in_rx_bytes == SETUP_BYTES) begin
            req_nxt   = in_length;
            pend_nxt  = 16'd0;
            soff_nxt  = 12'd0;
            short_nxt = 1'b0;
          end
        end
        OP_START_OUT: begin
          pend_nxt  = 16'd0;
          phase_nxt = (in_length > MP16) ? PH_DATA_OUT : PH_LAST_OUT;
        end
        OP_START_IN, OP_IN_SENT: begin
          if (op == OP_START_IN || phase_r == PH_DATA_IN) begin
            phase_nxt = snd_phase;
            if (snd_more) begin
              pend_nxt  = snd_pend - MP16;
              soff_nxt  = snd_soff + MP12;
              short_nxt = snd_short;
            end else begin
              pend_nxt  = 16'd0;
              soff_nxt  = 12'd0;
              short_nxt = 1'b0;
            end
          end else if (phase_r == PH_LAST_IN) begin
            phase_nxt = PH_STATUS_OUT;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        OP_OUT_RCVD: begin
          case (phase_r)
            PH_DATA_OUT, PH_LAST_OUT: begin
              if (take_ok) begin
                pend_nxt = take_sum[15:0];
                if (phase_r == PH_LAST_OUT) begin
                  phase_nxt = PH_STATUS_IN;
                end else begin
                  phase_nxt = take_last ? PH_LAST_OUT : PH_DATA_OUT;
                end
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Result word for the accepted event
  always_comb begin
    res                   = '0;
    res.action            = ACT_NONE;
    res.phase_after       = phase_nxt;
    case (op)
      OP_SETUP: begin
        if (in_rx_bytes == SETUP_BYTES) begin
          res.action            = ACT_SETUP_OK;
          res.max_buffer_length = (in_length < MT16) ? in_length[11:0] : MT16[11:0];
        end else begin
          res.action = ACT_STALL;
        end
      end
      OP_START_OUT: begin
        res.action = ACT_ARM_OUT;
      end
      OP_START_IN, OP_IN_SENT: begin
        if (op == OP_START_IN || phase_r == PH_DATA_IN) begin
          res.action        = ACT_SEND;
          res.buffer_offset = snd_soff;
          res.byte_count    = snd_more ? MP7 : snd_pend[6:0];
        end else if (phase_r == PH_LAST_IN) begin
          res.action = ACT_ARM_OUT;
        end else if (phase_r == PH_STATUS_IN) begin
          res.action = ACT_RX_DONE;
        end else begin
          res.action = ACT_STALL;
        end
      end
      OP_OUT_RCVD: begin
        case (phase_r)
          PH_DATA_OUT, PH_LAST_OUT: begin
            if (take_ok) begin
              res.action        = (phase_r == PH_LAST_OUT) ? ACT_TAKE_LAST : ACT_TAKE;
              res.byte_count    = pkt;
              res.buffer_offset = pend_r[11:0];
            end else begin
              res.action = ACT_STALL;
            end
          end
          PH_STATUS_OUT: begin
            res.action = ACT_TX_DONE;
          end
          default: begin
            res.action = ACT_STALL;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Result buffer: fill the output register first, spill into the skid
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pend_r       <= 16'd0;
      req_r        <= 16'd0;
      soff_r       <= 12'd0;
      short_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      req_r        <= req_nxt;
      soff_r       <= soff_nxt;
      short_r      <= short_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_action            = out_r.action;
  assign out_byte_count        = out_r.byte_count;
  assign out_buffer_offset     = out_r.buffer_offset;
  assign out_max_buffer_length = out_r.max_buffer_length;
  assign out_phase_after       = out_r.phase_after;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while the output register is empty");

  a_spill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("accepted word lost while the output was stalled");

  a_pend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= MT16)
    else $error("pending length beyond transfer buffer");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.byte_count <= MP7))
    else $error("packet byte count above max packet size");

  a_stall_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.action == ACT_STALL) |-> (out_r.phase_after == PH_IDLE))
    else $error("stall left the endpoint out of idle");

endmodule

[dv/tb_control_endpoint_sequencer.sv]
// Self-checking testbench for the endpoint-0 control transfer sequencer.
module tb_control_endpoint_sequencer;
  import ces_pkg::*;

  localparam int EP0_MAX_PACKET   = 64;
  localparam int EP0_MAX_TRANSFER = 2048;

  // Op codes the block has no meaning for; they must give no action.
  localparam int OP_RESERVED_FIRST = 5;
  localparam int OP_RESERVED_LAST  = 7;

  class transfer_scoreboard;
    phase_t      phase;
    logic [15:0] pending_len;
    logic [15:0] request_len;
    logic [11:0] send_offs;
    bit          zlp_due;
    bit          out_nak;
    result_t     expected_q[$];
    int unsigned fail_count;

    function new();
      phase       = PH_IDLE;
      pending_len = '0;
      request_len = '0;
      send_offs   = '0;
      zlp_due     = 1'b0;
      out_nak     = 1'b1;
      fail_count  = 0;
    endfunction

    // Size of the next OUT packet, zero once the request is covered.
    function logic [6:0] out_packet_size();
      logic [15:0] rem;
      rem = (request_len > pending_len) ? request_len - pending_len : 16'd0;
      return (rem < EP0_MAX_PACKET) ? rem[6:0] : 7'(EP0_MAX_PACKET);
    endfunction

    function void send_packet(output logic [6:0] cnt, output logic [11:0] offs);
      offs = send_offs;
      if (pending_len > EP0_MAX_PACKET) begin
        cnt         = 7'(EP0_MAX_PACKET);
        phase       = PH_DATA_IN;
        send_offs   = send_offs + 12'(EP0_MAX_PACKET);
        pending_len = pending_len - 16'(EP0_MAX_PACKET);
      end else begin
        cnt         = pending_len[6:0];
        phase       = zlp_due ? PH_DATA_IN : PH_LAST_IN;
        send_offs   = '0;
        zlp_due     = 1'b0;
        pending_len = '0;
      end
    endfunction

    function bit take_packet(input logic [6:0] rx, output logic [6:0] cnt,
                             output logic [11:0] offs);
      logic [6:0] pkt;
      pkt  = out_packet_size();
      cnt  = '0;
      offs = '0;
      if (rx < pkt || int'(pending_len) + int'(pkt) > EP0_MAX_TRANSFER) begin
        phase = PH_IDLE;
        return 1'b0;
      end
      offs        = pending_len[11:0];
      cnt         = pkt;
      pending_len = pending_len + 16'(pkt);
      return 1'b1;
    endfunction

    function result_t predict_action(logic [2:0] op, logic [15:0] len, logic [6:0] rx);
      result_t     r;
      logic [15:0] reply;
      logic [6:0]  cnt;
      logic [11:0] offs;
      r        = '0;
      r.action = ACT_NONE;
      case (op)
        OP_SETUP: begin
          out_nak = 1'b1;
          if (rx != SETUP_BYTES) begin
            r.action = ACT_STALL;
            phase    = PH_IDLE;
          end else begin
            request_len         = len;
            r.max_buffer_length = (len < EP0_MAX_TRANSFER) ? len[11:0]
                                                           : 12'(EP0_MAX_TRANSFER);
            phase               = PH_IDLE;
            pending_len         = '0;
            send_offs           = '0;
            zlp_due             = 1'b0;
            r.action            = ACT_SETUP_OK;
          end
        end
        OP_START_IN: begin
          reply = len;
          if (reply > request_len) reply = request_len;
          if (reply > EP0_MAX_TRANSFER) reply = 16'(EP0_MAX_TRANSFER);
          pending_len = reply;
          send_offs   = '0;
          zlp_due     = reply != 0 && reply < request_len && (reply % EP0_MAX_PACKET) == 0;
          send_packet(cnt, offs);
          r.byte_count    = cnt;
          r.buffer_offset = offs;
          r.action        = ACT_SEND;
        end
        OP_START_OUT: begin
          pending_len = '0;
          phase       = (len > EP0_MAX_PACKET) ? PH_DATA_OUT : PH_LAST_OUT;
          out_nak     = 1'b0;
          r.action    = ACT_ARM_OUT;
        end
        OP_IN_SENT: begin
          case (phase)
            PH_DATA_IN: begin
              send_packet(cnt, offs);
              r.byte_count    = cnt;
              r.buffer_offset = offs;
              r.action        = ACT_SEND;
            end
            PH_LAST_IN: begin
              phase    = PH_STATUS_OUT;
              out_nak  = 1'b0;
              r.action = ACT_ARM_OUT;
            end
            PH_STATUS_IN: begin
              phase    = PH_IDLE;
              r.action = ACT_RX_DONE;
            end
            default: begin
              phase    = PH_IDLE;
              r.action = ACT_STALL;
            end
          endcase
        end
        OP_OUT_RCVD: begin
          case (phase)
            PH_DATA_OUT: begin
              if (take_packet(rx, cnt, offs)) begin
                r.action        = ACT_TAKE;
                r.byte_count    = cnt;
                r.buffer_offset = offs;
                if (request_len < pending_len ||
                    request_len - pending_len <= EP0_MAX_PACKET)
                  phase = PH_LAST_OUT;
              end else begin
                r.action = ACT_STALL;
              end
            end
            PH_LAST_OUT: begin
              if (take_packet(rx, cnt, offs)) begin
                r.action        = ACT_TAKE_LAST;
                r.byte_count    = cnt;
                r.buffer_offset = offs;
                phase           = PH_STATUS_IN;
              end else begin
                r.action = ACT_STALL;
              end
            end
            PH_STATUS_OUT: begin
              phase    = PH_IDLE;
              r.action = ACT_TX_DONE;
            end
            default: begin
              phase    = PH_IDLE;
              r.action = ACT_STALL;
            end
          endcase
        end
        default: ;
      endcase
      r.phase_after = phase;
      return r;
    endfunction

    function void note_word(logic [2:0] op, logic [15:0] len, logic [6:0] rx);
      expected_q.push_back(predict_action(op, len, rx));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual action %0d",
                 $time, got.action);
        return;
      end
      want = expected_q.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("buffer_offset", want.buffer_offset, got.buffer_offset);
      compare_field("max_buffer_length", want.max_buffer_length, got.max_buffer_length);
      compare_field("phase_after", want.phase_after, got.phase_after);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [15:0] in_length;
  logic [6:0]  in_rx_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_action;
  logic [6:0]  out_byte_count;
  logic [11:0] out_buffer_offset;
  logic [11:0] out_max_buffer_length;
  logic [2:0]  out_phase_after;

  // Words with a defined op accepted so far; reserved ops do not count.
  int unsigned words_sent = 0;
  bit          held_off   = 1'b0;
  int unsigned hold_left  = 0;

  transfer_scoreboard sb = new();

  // Both sides stop idling over this stretch so that words go back to back.
  wire quiet_stretch = (words_sent >= 600 && words_sent < 800);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  control_endpoint_sequencer u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_length             (in_length),
    .in_rx_bytes           (in_rx_bytes),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_action            (out_action),
    .out_byte_count        (out_byte_count),
    .out_buffer_offset     (out_buffer_offset),
    .out_max_buffer_length (out_max_buffer_length),
    .out_phase_after       (out_phase_after)
  );

  // Mostly short transfers, with some exact packet multiples, some near the
  // buffer size and a few anywhere in the 16-bit range.
  function automatic logic [15:0] pick_length();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 16'($urandom_range(0, 200));
    if (k < 70) return 16'(EP0_MAX_PACKET * $urandom_range(0, 8));
    if (k < 85) return 16'($urandom_range(0, 1024));
    if (k < 95) return 16'($urandom_range(1900, 2200));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one word, idling at random first; return once it has been taken.
  // Valid is only lowered during an idle cycle, never between two words.
  task automatic send_word(input logic [2:0] op, input logic [15:0] len,
                           input logic [6:0] rx);
    while (!quiet_stretch && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_length   <= len;
    in_rx_bytes <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(op, len, rx);
    if (op <= OP_OUT_RCVD) words_sent++;
  endtask

  // Any op at all, reserved ones too; setups often carry a proper size.
  task automatic send_noise();
    logic [2:0]  op;
    logic [15:0] len;
    logic [6:0]  rx;
    op  = 3'($urandom_range(0, OP_RESERVED_LAST));
    len = ($urandom_range(0, 1) == 0) ? pick_length() : 16'($urandom);
    rx  = ($urandom_range(0, 2) == 0) ? SETUP_BYTES : 7'($urandom_range(0, 64));
    send_word(op, len, rx);
  endtask

  // Sink: stall at random, except for the quiet stretch; once, hold off
  // for a long run of cycles while the sender keeps pushing so that the
  // result buffer fills and in_ready drops.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && words_sent >= 300) begin
        held_off  = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (quiet_stretch) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Check every result word on the edge where it is taken.
  always @(posedge clk) begin : p_result_check
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.action            = action_t'(out_action);
      got.byte_count        = out_byte_count;
      got.buffer_offset     = out_buffer_offset;
      got.max_buffer_length = out_max_buffer_length;
      got.phase_after       = phase_t'(out_phase_after);
      sb.check_result(got);
    end
  end

  initial begin
    int          kind;
    int          guard;
    int          k;
    logic [15:0] req_len;
    logic [15:0] reply_len;
    logic [6:0]  pkt;
    logic [6:0]  rx;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= OP_SETUP;
    in_length   <= '0;
    in_rx_bytes <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words first.
    // Events that arrive in the wrong phase: stall.
    send_word(OP_IN_SENT, 16'hFFFF, 7'd64);
    send_word(OP_OUT_RCVD, 16'h0000, 7'd0);
    // Setup with the wrong byte count: stall.
    send_word(OP_SETUP, 16'd64, 7'd0);
    send_word(OP_SETUP, 16'd64, 7'd64);
    // Reserved ops: no action, nothing changes.
    for (k = OP_RESERVED_FIRST; k <= OP_RESERVED_LAST; k++)
      send_word(3'(k), 16'hFFFF, 7'd64);
    // Largest request: clip the buffer length.
    send_word(OP_SETUP, 16'hFFFF, SETUP_BYTES);
    // Reply longer than the request: clip it, two packets, then status.
    send_word(OP_SETUP, 16'd100, SETUP_BYTES);
    send_word(OP_START_IN, 16'hFFFF, 7'd0);
    send_word(OP_IN_SENT, 16'd0, 7'd0);
    send_word(OP_IN_SENT, 16'd0, 7'd0);
    send_word(OP_OUT_RCVD, 16'd0, 7'd0);
    // Reply a packet multiple shorter than the request: trailing empty packet.
    send_word(OP_SETUP, 16'd200, SETUP_BYTES);
    send_word(OP_START_IN, 16'd128, 7'd0);
    send_word(OP_IN_SENT, 16'd0, 7'd0);
    send_word(OP_IN_SENT, 16'd0, 7'd0);
    send_word(OP_IN_SENT, 16'd0, 7'd0);
    send_word(OP_OUT_RCVD, 16'd0, 7'd0);
    // Start a long read, then abort it with a fresh setup.
    send_word(OP_SETUP, 16'd300, SETUP_BYTES);
    send_word(OP_START_IN, 16'd300, 7'd0);
    send_word(OP_SETUP, 16'd100, SETUP_BYTES);
    // Short OUT packet: stall.
    send_word(OP_START_OUT, 16'd100, 7'd0);
    send_word(OP_OUT_RCVD, 16'd0, 7'd10);

    // Random part: mostly whole control reads and writes with random sizes,
    // sprinkled with stray words that break the sequence.
    while (words_sent < 1300) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Control read: setup, IN data stage, OUT status.
        req_len = pick_length();
        send_word(OP_SETUP, req_len, SETUP_BYTES);
        case ($urandom_range(0, 2))
          0:       reply_len = req_len;
          1:       reply_len = 16'(EP0_MAX_PACKET * $urandom_range(0, 6));
          default: reply_len = pick_length();
        endcase
        send_word(OP_START_IN, reply_len, 7'($urandom_range(0, 64)));
        guard = 0;
        while ((sb.phase == PH_DATA_IN || sb.phase == PH_LAST_IN) && guard < 80) begin
          if ($urandom_range(0, 99) < 3) send_noise();
          else send_word(OP_IN_SENT, 16'($urandom), 7'($urandom_range(0, 64)));
          guard++;
        end
        if (sb.phase == PH_STATUS_OUT)
          send_word(OP_OUT_RCVD, 16'($urandom), 7'($urandom_range(0, 64)));
      end else if (kind < 75) begin
        // Control write: setup, OUT data stage, IN status.
        req_len = pick_length();
        send_word(OP_SETUP, req_len, SETUP_BYTES);
        reply_len = ($urandom_range(0, 4) == 0) ? pick_length() : req_len;
        send_word(OP_START_OUT, reply_len, 7'($urandom_range(0, 64)));
        guard = 0;
        while ((sb.phase == PH_DATA_OUT || sb.phase == PH_LAST_OUT) && guard < 80) begin
          k   = $urandom_range(0, 99);
          pkt = sb.out_packet_size();
          if (k < 3) begin
            send_noise();
          end else begin
            if (k < 8) rx = 7'($urandom_range(0, 64));
            else if (k < 20) rx = pkt + 7'($urandom_range(0, 64 - int'(pkt)));
            else rx = pkt;
            send_word(OP_OUT_RCVD, 16'($urandom), rx);
          end
          guard++;
        end
        if (sb.phase == PH_STATUS_IN)
          send_word(OP_IN_SENT, 16'($urandom), 7'($urandom_range(0, 64)));
      end else begin
        send_noise();
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep clocking so that any stray word can still show.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[control_endpoint_sequencer.f]
sv/ces_pkg.sv
sv/control_endpoint_sequencer.sv
dv/tb_control_endpoint_sequencer.sv
